// ===== hw/rtl/dcsv_pkg.sv =====
// dcsv_pkg: shared types, prefix state codes and sizing constants for the
// DC size VLC decoder. Used by every module under hw/rtl.
package dcsv_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COEFF_W = 9;
    localparam int SIZE_W  = 4;
    localparam int LEN_W   = 4;
    localparam int POS_W   = 19;

    // Largest bit offset range the start_bit field can carry
    localparam int unsigned POS_FIELD_LIMIT = 32'd1 << POS_W;

    // Default stream length in bytes
    localparam int unsigned MAX_STREAM_BYTES_DEF = 65536;

    // Decoder state codes: code start, inside the prefix, reading value bits
    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_0     = 4'd1;
    localparam logic [3:0] ST_1     = 4'd2;
    localparam logic [3:0] ST_10    = 4'd3;
    localparam logic [3:0] ST_11    = 4'd4;
    localparam logic [3:0] ST_111   = 4'd5;
    localparam logic [3:0] ST_1111  = 4'd6;
    localparam logic [3:0] ST_11111 = 4'd7;
    localparam logic [3:0] ST_VALUE = 4'd8;

    // One stream byte as held in the input queue
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } byte_item_t;

    // One decoded code
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff_value;
        logic [SIZE_W-1:0]         value_size;
        logic [LEN_W-1:0]          code_length;
        logic [POS_W-1:0]          start_bit;
        logic                      last_of_run;
    } result_t;

endpackage

// ===== hw/rtl/dc_size_vlc_decoder.sv =====
// dc_size_vlc_decoder: top level; input byte queue, bit-serial decode
// engine and result queue. Depends on dcsv_pkg, dcsv_front, dcsv_engine, dcsv_outq.
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------------
//   input    in_valid / in_stall  data_byte, end_of_stream
//   output   out_valid/out_stall  coeff_value, value_size, code_length,
//                                 start_bit, last_of_run
//
// The engine decodes one stream bit per cycle while a byte waits and the result
// queue has room; a final byte whose code is still open then takes padding bits.
// Results pass through a four-entry queue; the engine steps only while two
// slots are free, so a stalled output eventually holds the engine and then input.
// Reset clears the decoder state, bit position and both queues at once.
module dc_size_vlc_decoder
    import dcsv_pkg::*;
#(
    parameter int unsigned MAX_STREAM_BYTES = MAX_STREAM_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [BYTE_W-1:0]         data_byte,
    input  logic                      end_of_stream,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COEFF_W-1:0] coeff_value,
    output logic [SIZE_W-1:0]         value_size,
    output logic [LEN_W-1:0]          code_length,
    output logic [POS_W-1:0]          start_bit,
    output logic                      last_of_run
);

    byte_item_t in_item;
    byte_item_t byte_head;
    logic       byte_valid;
    logic       byte_pop;
    logic       room;
    logic [1:0] wr_cnt;
    result_t    wr_a;
    result_t    wr_b;
    result_t    out_head;

    assign in_item.data_byte     = data_byte;
    assign in_item.end_of_stream = end_of_stream;

    dcsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .byte_valid (byte_valid),
        .byte_head  (byte_head),
        .byte_pop   (byte_pop)
    );

    dcsv_engine #(
        .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_head  (byte_head),
        .byte_pop   (byte_pop),
        .room       (room),
        .wr_cnt     (wr_cnt),
        .wr_a       (wr_a),
        .wr_b       (wr_b)
    );

    dcsv_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_head  (out_head)
    );

    // Unpack the head result onto the ports
    assign coeff_value = out_head.coeff_value;
    assign value_size  = out_head.value_size;
    assign code_length = out_head.code_length;
    assign start_bit   = out_head.start_bit;
    assign last_of_run = out_head.last_of_run;

endmodule

// ===== hw/rtl/dcsv_front.sv =====
// dcsv_front: input side; accepts stream bytes into a two-entry queue and
// hands them to the bit engine. Depends on dcsv_pkg.
module dcsv_front
    import dcsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  byte_item_t in_item,
    output logic       byte_valid,
    output byte_item_t byte_head,
    input  logic       byte_pop
);

    byte_item_t  q_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;

    // Stall only when both entries hold a byte
    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign byte_valid = (cnt_reg != 2'd0);
    assign byte_head  = q_reg[rp_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = byte_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, byte_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the accepted beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

    // The engine only takes a byte that is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pop |-> byte_valid)
        else $error("byte popped from empty input queue");

endmodule

// ===== hw/rtl/dcsv_engine.sv =====
// dcsv_engine: bit-serial VLC decode, one stream or padding bit per cycle while a
// byte waits and the queue has room, with a held result that learns its end-of-byte mark. Depends on dcsv_pkg.
module dcsv_engine
    import dcsv_pkg::*;
#(
    parameter int unsigned MAX_STREAM_BYTES = MAX_STREAM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  byte_item_t byte_head,
    output logic       byte_pop,
    input  logic       room,
    output logic [1:0] wr_cnt,
    output result_t    wr_a,
    output result_t    wr_b
);

    localparam int unsigned LIM_RAW = MAX_STREAM_BYTES * 8;
    localparam logic [POS_W:0] POS_LIMIT =
        (POS_W+1)'((LIM_RAW > POS_FIELD_LIMIT) ? POS_FIELD_LIMIT : LIM_RAW);

    logic [3:0]         ps_reg, ps_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [7:0]         vshift_reg, vshift_next;
    logic [3:0]         vleft_reg, vleft_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   cs_reg, cs_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [2:0]         idx_reg, idx_next;
    logic               pad_reg, pad_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;

    logic               advance;
    logic               bit_in;
    logic [POS_W:0]     pos_inc;
    logic [3:0]         ps_f;
    logic [SIZE_W-1:0]  size_f;
    logic [7:0]         vs_f;
    logic [3:0]         vl_f;
    logic [3:0]         vl_dec;
    logic [LEN_W-1:0]   cnt_f;
    logic [POS_W-1:0]   cs_f;
    logic [POS_W-1:0]   pos_f;
    logic               emit;
    logic               bv;
    logic [SIZE_W-1:0]  bsize;
    logic [COEFF_W-1:0] full9;
    logic [COEFF_W-1:0] half9;
    logic [COEFF_W-1:0] vext;
    logic [COEFF_W-1:0] coeff;
    logic               done;
    logic               clear;
    logic               e_push;
    logic               d_push;
    logic               push0;
    logic               push1;
    result_t            res;

    assign advance = byte_valid && room;
    assign bit_in  = pad_reg ? 1'b0 : byte_head.data_byte[3'd7 - idx_reg];

    // Decode one bit: bookkeeping, prefix walk, value shift
    always_comb
    begin
        cs_f    = (ps_reg == ST_START) ? pos_reg : cs_reg;
        cnt_f   = (ps_reg == ST_START) ? '0 : cnt_reg;
        pos_f   = pos_reg;
        pos_inc = {1'b0, pos_reg} + 1'b1;
        if (!pad_reg)
        begin
            cnt_f = cnt_f + 1'b1;
            pos_f = (pos_inc >= POS_LIMIT) ? '0 : pos_inc[POS_W-1:0];
        end

        ps_f   = ps_reg;
        size_f = size_reg;
        vs_f   = vshift_reg;
        vl_f   = vleft_reg;
        vl_dec = (vleft_reg != 4'd0) ? vleft_reg - 4'd1 : vleft_reg;
        emit   = 1'b0;
        bv     = 1'b0;
        bsize  = '0;
        case (ps_reg)
            ST_START: ps_f = bit_in ? ST_1 : ST_0;
            ST_0:
            begin
                bv    = 1'b1;
                bsize = bit_in ? 4'd2 : 4'd1;
            end
            ST_1: ps_f = bit_in ? ST_11 : ST_10;
            ST_10:
            begin
                bv    = 1'b1;
                bsize = bit_in ? 4'd3 : 4'd0;
            end
            ST_11:
            begin
                if (bit_in) ps_f = ST_111;
                else
                begin
                    bv    = 1'b1;
                    bsize = 4'd4;
                end
            end
            ST_111:
            begin
                if (bit_in) ps_f = ST_1111;
                else
                begin
                    bv    = 1'b1;
                    bsize = 4'd5;
                end
            end
            ST_1111:
            begin
                if (bit_in) ps_f = ST_11111;
                else
                begin
                    bv    = 1'b1;
                    bsize = 4'd6;
                end
            end
            ST_11111:
            begin
                bv    = 1'b1;
                bsize = bit_in ? 4'd8 : 4'd7;
            end
            default:
            begin
                vs_f = {vshift_reg[6:0], bit_in};
                vl_f = vl_dec;
                emit = (vl_dec == 4'd0);
            end
        endcase

        // Prefix complete: load the size, finish at once for zero size
        if (bv)
        begin
            size_f = bsize;
            vs_f   = '0;
            vl_f   = bsize;
            if (bsize == 4'd0) emit = 1'b1;
            else               ps_f = ST_VALUE;
        end
        if (emit)
        begin
            ps_f = ST_START;
        end
    end

    // Map the gathered bits to a signed value
    always_comb
    begin
        full9 = 9'd1 << size_f;
        half9 = 9'd1 << (size_f - 4'd1);
        vext  = {1'b0, vs_f};
        if (size_f == 4'd0)   coeff = '0;
        else if (vext < half9) coeff = vext - full9 + 9'd1;
        else                   coeff = vext;

        res.coeff_value = coeff;
        res.value_size  = size_f;
        res.code_length = cnt_f;
        res.start_bit   = cs_f;
        res.last_of_run = 1'b0;
    end

    // Byte finished after its last real bit, or once padding closes the code
    always_comb
    begin
        if (pad_reg)
            done = (ps_f == ST_START);
        else
            done = (idx_reg == 3'd7) && (!byte_head.end_of_stream || ps_f == ST_START);
        clear    = done && byte_head.end_of_stream;
        byte_pop = advance && done;
        pad_next = advance ? (byte_head.end_of_stream && !done && (pad_reg || idx_reg == 3'd7))
                           : pad_reg;
        idx_next = (advance && !pad_reg) ? idx_reg + 3'd1 : idx_reg;
    end

    // Release the held result: not last if another follows in this byte
    always_comb
    begin
        e_push = advance && emit;
        d_push = advance && done;
        push0  = pend_valid_reg && (e_push || d_push);
        push1  = e_push && d_push;
        wr_b   = res;
        wr_b.last_of_run = 1'b1;
        if (push0)
        begin
            wr_a = pend_reg;
            wr_a.last_of_run = !e_push;
        end
        else
        begin
            wr_a = wr_b;
        end
        wr_cnt = {1'b0, push0} + {1'b0, push1};

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (d_push)
        begin
            pend_valid_next = 1'b0;
        end
        else if (e_push)
        begin
            pend_valid_next = 1'b1;
            pend_next       = res;
        end
    end

    // Next decoder state, cleared after the final byte of a stream
    always_comb
    begin
        ps_next     = ps_reg;
        size_next   = size_reg;
        vshift_next = vshift_reg;
        vleft_next  = vleft_reg;
        cnt_next    = cnt_reg;
        cs_next     = cs_reg;
        pos_next    = pos_reg;
        if (advance)
        begin
            if (clear)
            begin
                ps_next     = ST_START;
                size_next   = '0;
                vshift_next = '0;
                vleft_next  = '0;
                cnt_next    = '0;
                cs_next     = '0;
                pos_next    = '0;
            end
            else
            begin
                ps_next     = ps_f;
                size_next   = size_f;
                vshift_next = vs_f;
                vleft_next  = vl_f;
                cnt_next    = cnt_f;
                cs_next     = cs_f;
                pos_next    = pos_f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg         <= ST_START;
            size_reg       <= '0;
            vshift_reg     <= '0;
            vleft_reg      <= '0;
            cnt_reg        <= '0;
            cs_reg         <= '0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            pad_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            ps_reg         <= ps_next;
            size_reg       <= size_next;
            vshift_reg     <= vshift_next;
            vleft_reg      <= vleft_next;
            cnt_reg        <= cnt_next;
            cs_reg         <= cs_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            pad_reg        <= pad_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Padding only runs on a final byte whose real bits are all used
    a_pad_eos: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> (byte_valid && byte_head.end_of_stream && idx_reg == 3'd0))
        else $error("padding outside a final byte");

    // Two results at once only when a byte closes
    a_two_push: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_cnt == 2'd2) |-> byte_pop)
        else $error("double write without byte end");

    // No result is held across a byte boundary
    a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pop |=> !pend_valid_reg)
        else $error("held result survived byte end");

endmodule

// ===== hw/rtl/dcsv_outq.sv =====
// dcsv_outq: result queue, four entries, up to two writes and one read per
// cycle; decouples the bit engine from the output stall. Depends on dcsv_pkg.
module dcsv_outq
    import dcsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_cnt,
    input  result_t    wr_a,
    input  result_t    wr_b,
    output logic       room,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    out_head
);

    localparam int DEPTH = 4;

    result_t     q_reg [DEPTH];
    logic [1:0]  wp_reg, wp_next;
    logic [1:0]  rp_reg, rp_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pop;

    // Engine may step only with space for two writes
    assign room      = (cnt_reg <= 3'(DEPTH - 2));
    assign out_valid = (cnt_reg != 3'd0);
    assign out_head  = q_reg[rp_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wp_next  = wp_reg + wr_cnt;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, wr_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write the beats in order
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            q_reg[wp_reg] <= wr_a;
        end
        if (wr_cnt == 2'd2)
        begin
            q_reg[wp_reg + 2'd1] <= wr_b;
        end
    end

    // Fill count never passes the depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(DEPTH))
        else $error("result queue overflow");

endmodule

// ===== sim/dc_size_vlc_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dc_size_vlc_decoder: bit-serial prediction of every decoded
// DC size code, checked in order against the result channel. Depends on dcsv_pkg and the RTL.
module dc_size_vlc_decoder_tb
    import dcsv_pkg::*;
;

    // Stream limit, handed down through the top level
    localparam int STREAM_BYTES = 256;
    localparam int POS_WRAP     = (STREAM_BYTES * 8 > POS_FIELD_LIMIT) ?
                                  POS_FIELD_LIMIT : STREAM_BYTES * 8;
    localparam int RANDOM_BYTES = 156;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [BYTE_W-1:0]         data_byte = '0;
    logic                      end_of_stream = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COEFF_W-1:0] coeff_value;
    logic [SIZE_W-1:0]         value_size;
    logic [LEN_W-1:0]          code_length;
    logic [POS_W-1:0]          start_bit;
    logic                      last_of_run;

    // Tracks the decoder state and holds the codes still owed by the block
    class dc_code_tracker;
        logic [3:0]        pstate    = ST_START;
        logic [SIZE_W-1:0] size_q    = '0;
        logic [7:0]        val_acc   = '0;
        logic [3:0]        bits_left = '0;
        logic [LEN_W-1:0]  code_len  = '0;
        logic [POS_W-1:0]  code_pos  = '0;
        logic [POS_W-1:0]  bit_pos   = '0;
        result_t           expected_codes[$];
        int                fail_count = 0;

        task report_mismatch(string what);
            if (fail_count < 100)
                $display("[%0t] mismatch: %s", $time, what);
            fail_count++;
        endtask

        // Finish the open code and queue its result
        function void close_code();
            int      v;
            result_t r;
            v = 0;
            if (size_q != 0)
            begin
                v = val_acc;
                if (v < (1 << (size_q - 1)))
                    v = v - (1 << size_q) + 1;
            end
            r.coeff_value = v[COEFF_W-1:0];
            r.value_size  = size_q;
            r.code_length = code_len;
            r.start_bit   = code_pos;
            r.last_of_run = 1'b0;
            expected_codes.push_back(r);
            pstate = ST_START;
        endfunction

        function void open_value(int unsigned sz);
            size_q    = sz[SIZE_W-1:0];
            val_acc   = '0;
            bits_left = sz[3:0];
            if (sz == 0)
                close_code();
            else
                pstate = ST_VALUE;
        endfunction

        // Advance by one stream bit; padding bits are not counted
        function void take_bit(logic b, logic counted);
            if (pstate == ST_START)
            begin
                code_pos = bit_pos;
                code_len = '0;
            end
            if (counted)
            begin
                code_len = code_len + 1'b1;
                if (bit_pos == POS_W'(POS_WRAP - 1))
                    bit_pos = '0;
                else
                    bit_pos = bit_pos + 1'b1;
            end
            case (pstate)
                ST_START: pstate = b ? ST_1 : ST_0;
                ST_0:     open_value(b ? 2 : 1);
                ST_1:     pstate = b ? ST_11 : ST_10;
                ST_10:    open_value(b ? 3 : 0);
                ST_11:    if (b) pstate = ST_111; else open_value(4);
                ST_111:   if (b) pstate = ST_1111; else open_value(5);
                ST_1111:  if (b) pstate = ST_11111; else open_value(6);
                ST_11111: open_value(b ? 8 : 7);
                default:
                begin
                    val_acc = {val_acc[6:0], b};
                    if (bits_left != 0)
                        bits_left = bits_left - 1'b1;
                    if (bits_left == 0)
                        close_code();
                end
            endcase
        endfunction

        // Predict the codes completed by one accepted beat
        function void decode_byte(logic [7:0] d, logic eos);
            int n_before;
            int guard;
            n_before = expected_codes.size();
            for (int i = 7; i >= 0; i--)
                take_bit(d[i], 1'b1);
            if (eos)
            begin
                // pad an open code with zeros, then start a fresh stream
                guard = 0;
                while (pstate != ST_START && guard < 16)
                begin
                    take_bit(1'b0, 1'b0);
                    guard++;
                end
                pstate    = ST_START;
                size_q    = '0;
                val_acc   = '0;
                bits_left = '0;
                code_len  = '0;
                code_pos  = '0;
                bit_pos   = '0;
            end
            if (expected_codes.size() > n_before)
                expected_codes[expected_codes.size() - 1].last_of_run = 1'b1;
        endfunction

        // Compare one result beat with the oldest expected code
        task check_code(result_t got);
            result_t want;
            if (expected_codes.size() == 0)
                report_mismatch("result beat with no code expected");
            else
            begin
                want = expected_codes.pop_front();
                if (got.coeff_value !== want.coeff_value)
                    report_mismatch($sformatf("coeff_value got %0d expected %0d",
                        $signed(got.coeff_value), $signed(want.coeff_value)));
                if (got.value_size !== want.value_size)
                    report_mismatch($sformatf("value_size got %0d expected %0d",
                        got.value_size, want.value_size));
                if (got.code_length !== want.code_length)
                    report_mismatch($sformatf("code_length got %0d expected %0d",
                        got.code_length, want.code_length));
                if (got.start_bit !== want.start_bit)
                    report_mismatch($sformatf("start_bit got %0d expected %0d",
                        got.start_bit, want.start_bit));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run got %0b expected %0b",
                        got.last_of_run, want.last_of_run));
            end
        endtask
    endclass

    dc_code_tracker tracker = new;

    bit stream_bits[$];
    int bytes_sent = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    dc_size_vlc_decoder #(
        .MAX_STREAM_BYTES(STREAM_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coeff_value  (coeff_value),
        .value_size   (value_size),
        .code_length  (code_length),
        .start_bit    (start_bit),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both channels; input beats are predicted before results are checked
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.decode_byte(data_byte, end_of_stream);
            if (out_valid && !out_stall)
            begin
                got.coeff_value = coeff_value;
                got.value_size  = value_size;
                got.code_length = code_length;
                got.start_bit   = start_bit;
                got.last_of_run = last_of_run;
                tracker.check_code(got);
            end
        end
    end

    // Receiver: long hold on request, otherwise rotate free, random and fixed stall patterns
    initial
    begin : receiver
        int phase;
        int mode;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            phase++;
            mode = (phase / 300) % 3;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ((phase % 7) < 3);
            endcase
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one beat and hold it until taken; idle between bursts
    task offer_byte(logic [7:0] d, logic eos);
        in_valid      <= 1'b1;
        data_byte     <= d;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if (!no_gaps)
            begin
                in_valid      <= 1'b0;
                data_byte     <= 8'($urandom);
                end_of_stream <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 14))
                    @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) :
                                                       $urandom_range(1, 8);
        end
    endtask

    // Append one code: size prefix, then the low sz bits of v, MSB first
    task add_code(int unsigned sz, logic [7:0] v);
        logic [5:0] pre;
        int         plen;
        case (sz)
            0:       begin pre = 6'b000100; plen = 3; end
            1:       begin pre = 6'b000000; plen = 2; end
            2:       begin pre = 6'b000001; plen = 2; end
            3:       begin pre = 6'b000101; plen = 3; end
            4:       begin pre = 6'b000110; plen = 3; end
            5:       begin pre = 6'b001110; plen = 4; end
            6:       begin pre = 6'b011110; plen = 5; end
            7:       begin pre = 6'b111110; plen = 6; end
            default: begin pre = 6'b111111; plen = 6; end
        endcase
        for (int i = plen - 1; i >= 0; i--)
            stream_bits.push_back(pre[i]);
        for (int i = int'(sz) - 1; i >= 0; i--)
            stream_bits.push_back(v[i]);
    endtask

    // Append random codes until the stream holds at least min_bits
    task build_codes(int min_bits);
        logic [7:0] v;
        while (stream_bits.size() < min_bits)
        begin
            case ($urandom_range(0, 4))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            add_code($urandom_range(0, 8), v);
        end
    endtask

    // Pack queued bits into beats; a short tail is filled with random real bits
    task send_stream(bit close);
        logic [7:0] d;
        logic       e;
        while (stream_bits.size() > 0)
        begin
            for (int i = 7; i >= 0; i--)
                d[i] = (stream_bits.size() > 0) ? stream_bits.pop_front() :
                                                  1'($urandom_range(0, 1));
            e = close && (stream_bits.size() == 0);
            offer_byte(d, e);
        end
    endtask

    initial
    begin : stimulus
        int random_start;
        bit pressure_done;
        pressure_done = 1'b0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every size with all-ones value, then value extremes and half-range edges
        for (int s = 0; s <= 8; s++)
            add_code(s, 8'hFF);
        add_code(8, 8'h00);
        add_code(8, 8'h80);
        add_code(8, 8'h7F);
        add_code(3, 8'h03);
        add_code(3, 8'h04);
        add_code(1, 8'h00);
        add_code(0, 8'h00);
        send_stream(1'b1);

        // final beats: long open code padded, short tail padded, zero size padded,
        // exact fit; then a beat with no result followed by a padded final beat
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'h00, 1'b1);
        offer_byte(8'h92, 1'b1);
        offer_byte(8'h44, 1'b1);
        offer_byte(8'hFC, 1'b0);
        offer_byte(8'h03, 1'b1);

        // random streams and noise; one long hold while beats keep coming
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (!pressure_done && bytes_sent - random_start >= 60)
            begin
                pressure_done = 1'b1;
                hold_req = 1'b1;
                no_gaps = 1'b1;
                build_codes(320);
                send_stream(1'b1);
                no_gaps = 1'b0;
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                build_codes($urandom_range(1, 96));
                send_stream($urandom_range(0, 4) != 0);
            end
            else
                offer_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end
        in_valid <= 1'b0;

        // drain, then allow for padding and queue latency
        while (tracker.expected_codes.size() != 0)
            @(posedge clk);
        repeat (64)
            @(posedge clk);

        if (tracker.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
